// File: sv/gfa_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes of the grid rectangle allocator
// no dependencies

package gfa_pkg;

    localparam int GRID_DIM_MAX   = 8;
    localparam int ENTRY_CAPACITY = 64;
    localparam int KEY_BITS       = 16;

    localparam int CELL_COUNT = GRID_DIM_MAX * GRID_DIM_MAX;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int POS_W      = $clog2(GRID_DIM_MAX);
    localparam int DIM_W      = 4;
    localparam int IDX_W      = $clog2(ENTRY_CAPACITY);
    localparam int CNT_W      = $clog2(ENTRY_CAPACITY + 1);
    localparam int ENT_W      = KEY_BITS + 2 * POS_W + 2 * DIM_W;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD_FIRST,
        OP_ADD_AT,
        OP_REMOVE,
        OP_QUERY
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK,
        STAT_DUP,
        STAT_NO_SPACE,
        STAT_NOT_FOUND,
        STAT_FULL
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_FIT,
        S_MARK,
        S_SHIFT,
        S_RENUM,
        S_QRD,
        S_QOWN,
        S_QKEY,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [15:0] item_key;
        logic [3:0] item_width;
        logic [3:0] item_height;
        logic [2:0] pos_x;
        logic [2:0] pos_y;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [2:0] place_x;
        logic [2:0] place_y;
        logic [6:0] occupant_index;
        logic [15:0] occupant_key;
        logic [6:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ent_port_t;

    typedef struct packed {
        logic              we;
        logic [CELL_W-1:0] waddr;
        logic [IDX_W-1:0]  wdata;
        logic [CELL_W-1:0] raddr;
    } grid_port_t;

endpackage

// File: sv/gfa_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies

module gfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/gfa_fit.sv
`timescale 1ns / 1ps
// rectangle cover mask and fit test against the occupancy bitmap
// depends on gfa_pkg

module gfa_fit (
    input  logic [gfa_pkg::CELL_COUNT-1:0] occ,
    input  logic [gfa_pkg::DIM_W-1:0]      cols,
    input  logic [gfa_pkg::DIM_W-1:0]      rows,
    input  logic [gfa_pkg::POS_W-1:0]      cx,
    input  logic [gfa_pkg::POS_W-1:0]      cy,
    input  logic [gfa_pkg::DIM_W-1:0]      w,
    input  logic [gfa_pkg::DIM_W-1:0]      h,
    output logic [gfa_pkg::CELL_COUNT-1:0] mask,
    output logic                           fit
);
    import gfa_pkg::*;

    localparam int E = DIM_W + 1;

    logic [E-1:0] x_end;
    logic [E-1:0] y_end;
    logic         bounds_ok;

    assign x_end = E'(cx) + E'(w);
    assign y_end = E'(cy) + E'(h);
    assign bounds_ok = (w != '0) && (h != '0) && (x_end <= E'(cols)) && (y_end <= E'(rows));

    always_comb
    begin
        for (int y = 0; y < GRID_DIM_MAX; y++)
        begin
            for (int x = 0; x < GRID_DIM_MAX; x++)
            begin
                mask[y * GRID_DIM_MAX + x] = (E'(x) >= E'(cx)) && (E'(x) < x_end)
                    && (E'(y) >= E'(cy)) && (E'(y) < y_end);
            end
        end
    end

    assign fit = bounds_ok && ((occ & mask) == '0);

endmodule

// File: sv/gfa_ctrl.sv
`timescale 1ns / 1ps
// sequencer: key scan, corner search, grid marking, entry shift, renumbering and cell query
// depends on gfa_pkg and gfa_fit

module gfa_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  gfa_pkg::req_t           req_data,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output gfa_pkg::rsp_t           rsp_data,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [3:0]              cfg_wdata,
    output gfa_pkg::ent_port_t      ent_port,
    input  gfa_pkg::entry_t         ent_rdata,
    output gfa_pkg::grid_port_t     grid_port,
    input  logic [gfa_pkg::IDX_W-1:0] grid_rdata
);
    import gfa_pkg::*;

    state_t                state_reg, state_next;
    logic [DIM_W-1:0]      cols_reg, cols_next;
    logic [DIM_W-1:0]      rows_reg, rows_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CELL_COUNT-1:0] occ_reg, occ_next;
    logic                  pend_reg, pend_next;
    logic                  rdone_reg, rdone_next;
    logic                  out_vld_reg, out_vld_next;
    req_t                  req_reg, req_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      pidx_reg, pidx_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      cx_reg, cx_next;
    logic [POS_W-1:0]      cy_reg, cy_next;
    logic [CELL_W-1:0]     cell_reg, cell_next;
    logic [CELL_W-1:0]     pcell_reg, pcell_next;
    rsp_t                  res_reg, res_next;
    rsp_t                  out_reg, out_next;

    logic [DIM_W-1:0]      cols_u;
    logic [DIM_W-1:0]      rows_u;
    logic [CELL_COUNT-1:0] mask;
    logic                  fit_ok;
    logic                  key_hit;
    logic                  scan_more;
    logic                  last_corner;
    logic                  is_remove;
    logic                  q_inside;
    logic [CELL_W-1:0]     q_cell;
    logic                  in_acc;
    logic                  out_load;

    assign cols_u = (cols_reg > DIM_W'(GRID_DIM_MAX)) ? DIM_W'(GRID_DIM_MAX) : cols_reg;
    assign rows_u = (rows_reg > DIM_W'(GRID_DIM_MAX)) ? DIM_W'(GRID_DIM_MAX) : rows_reg;

    gfa_fit u_fit (
        .occ  (occ_reg),
        .cols (cols_u),
        .rows (rows_u),
        .cx   (cx_reg),
        .cy   (cy_reg),
        .w    (req_reg.item_width),
        .h    (req_reg.item_height),
        .mask (mask),
        .fit  (fit_ok)
    );

    assign key_hit   = pend_reg && (ent_rdata.key == req_reg.item_key[KEY_BITS-1:0]);
    assign scan_more = idx_reg < cnt_reg;
    assign last_corner = !((DIM_W'(cx_reg) + 1'b1) < cols_u) && !((DIM_W'(cy_reg) + 1'b1) < rows_u);
    assign is_remove = req_reg.op == OP_REMOVE;
    assign q_cell    = CELL_W'(int'(req_reg.pos_y) * GRID_DIM_MAX + int'(req_reg.pos_x));
    assign q_inside  = (DIM_W'(req_reg.pos_x) < cols_u) && (DIM_W'(req_reg.pos_y) < rows_u)
        && occ_reg[q_cell];
    assign in_acc    = req_valid && !req_stall;
    assign out_load  = (state_reg == S_DONE) && (!out_vld_reg || !rsp_stall);

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = out_vld_reg;
    assign rsp_data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (req_data.op == OP_QUERY) ? S_QRD : S_FIND;
                end
            end
            S_FIND:
            begin
                if (key_hit)
                begin
                    state_next = is_remove ? S_SHIFT : S_DONE;
                end
                else if (!scan_more)
                begin
                    if (is_remove || cnt_reg >= CNT_W'(ENTRY_CAPACITY))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIT;
                    end
                end
            end
            S_FIT:
            begin
                if (fit_ok)
                begin
                    state_next = S_MARK;
                end
                else if (req_reg.op == OP_ADD_AT || last_corner)
                begin
                    state_next = S_DONE;
                end
            end
            S_MARK:
            begin
                if (cell_reg == CELL_W'(CELL_COUNT - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (!scan_more && !pend_reg)
                begin
                    state_next = S_RENUM;
                end
            end
            S_RENUM:
            begin
                if (rdone_reg && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_QRD:
            begin
                state_next = q_inside ? S_QOWN : S_DONE;
            end
            S_QOWN:
            begin
                state_next = S_QKEY;
            end
            S_QKEY:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        cols_next    = cols_reg;
        rows_next    = rows_reg;
        cnt_next     = cnt_reg;
        occ_next     = occ_reg;
        pend_next    = pend_reg;
        rdone_next   = rdone_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        pidx_next    = pidx_reg;
        pos_next     = pos_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cell_next    = cell_reg;
        pcell_next   = pcell_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg;

        ent_port.we     = 1'b0;
        ent_port.waddr  = pidx_reg - 1'b1;
        ent_port.wdata  = ent_rdata;
        ent_port.raddr  = idx_reg[IDX_W-1:0];
        grid_port.we    = 1'b0;
        grid_port.waddr = cell_reg;
        grid_port.wdata = cnt_reg[IDX_W-1:0];
        grid_port.raddr = cell_reg;

        if (rsp_valid && !rsp_stall)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    if (cfg_index == CFG_GRID_WIDTH)
                    begin
                        cols_next = cfg_wdata;
                    end
                    else
                    begin
                        rows_next = cfg_wdata;
                    end
                    cnt_next = '0;
                    occ_next = '0;
                end
                if (in_acc)
                begin
                    req_next = req_data;
                    idx_next = '0;
                    pend_next = 1'b0;
                    res_next = '{status: STAT_OK, place_x: '0, place_y: '0,
                        occupant_index: 7'(ENTRY_CAPACITY), occupant_key: '0,
                        entry_count: '0};
                end
            end
            S_FIND:
            begin
                if (key_hit)
                begin
                    pos_next  = pidx_reg;
                    idx_next  = CNT_W'(pidx_reg) + 1'b1;
                    pend_next = 1'b0;
                    if (!is_remove)
                    begin
                        res_next.status = STAT_DUP;
                    end
                end
                else if (scan_more)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (is_remove)
                    begin
                        res_next.status = STAT_NOT_FOUND;
                    end
                    else if (cnt_reg >= CNT_W'(ENTRY_CAPACITY))
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else if (req_reg.op == OP_ADD_AT)
                    begin
                        cx_next = req_reg.pos_x;
                        cy_next = req_reg.pos_y;
                    end
                    else
                    begin
                        cx_next = '0;
                        cy_next = '0;
                    end
                end
            end
            S_FIT:
            begin
                if (fit_ok)
                begin
                    occ_next             = occ_reg | mask;
                    ent_port.we          = 1'b1;
                    ent_port.waddr       = cnt_reg[IDX_W-1:0];
                    ent_port.wdata.key   = req_reg.item_key[KEY_BITS-1:0];
                    ent_port.wdata.x     = cx_reg;
                    ent_port.wdata.y     = cy_reg;
                    ent_port.wdata.w     = req_reg.item_width;
                    ent_port.wdata.h     = req_reg.item_height;
                    cell_next            = '0;
                end
                else if (req_reg.op == OP_ADD_AT || last_corner)
                begin
                    res_next.status = STAT_NO_SPACE;
                end
                else if ((DIM_W'(cx_reg) + 1'b1) < cols_u)
                begin
                    cx_next = cx_reg + 1'b1;
                end
                else
                begin
                    cx_next = '0;
                    cy_next = cy_reg + 1'b1;
                end
            end
            S_MARK:
            begin
                grid_port.we    = mask[cell_reg];
                grid_port.waddr = cell_reg;
                grid_port.wdata = cnt_reg[IDX_W-1:0];
                if (cell_reg == CELL_W'(CELL_COUNT - 1))
                begin
                    cnt_next         = cnt_reg + 1'b1;
                    res_next.place_x = cx_reg;
                    res_next.place_y = cy_reg;
                end
                else
                begin
                    cell_next = cell_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                ent_port.we    = pend_reg;
                ent_port.waddr = pidx_reg - 1'b1;
                ent_port.wdata = ent_rdata;
                ent_port.raddr = idx_reg[IDX_W-1:0];
                if (scan_more)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        cell_next  = '0;
                        rdone_next = 1'b0;
                    end
                end
            end
            S_RENUM:
            begin
                grid_port.raddr = cell_reg;
                grid_port.waddr = pcell_reg;
                grid_port.wdata = grid_rdata - 1'b1;
                if (pend_reg && occ_reg[pcell_reg])
                begin
                    if (grid_rdata == pos_reg)
                    begin
                        occ_next[pcell_reg] = 1'b0;
                    end
                    else if (grid_rdata > pos_reg)
                    begin
                        grid_port.we = 1'b1;
                    end
                end
                if (!rdone_reg)
                begin
                    pend_next  = 1'b1;
                    pcell_next = cell_reg;
                    if (cell_reg == CELL_W'(CELL_COUNT - 1))
                    begin
                        rdone_next = 1'b1;
                    end
                    else
                    begin
                        cell_next = cell_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            S_QRD:
            begin
                grid_port.raddr = q_cell;
                if (!q_inside)
                begin
                    res_next.status = STAT_NOT_FOUND;
                end
            end
            S_QOWN:
            begin
                ent_port.raddr = grid_rdata;
                pos_next       = grid_rdata;
            end
            S_QKEY:
            begin
                res_next.occupant_index = 7'(pos_reg);
                res_next.occupant_key   = 16'(ent_rdata.key);
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_next             = res_reg;
                    out_next.entry_count = 7'(cnt_reg);
                    out_vld_next         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cols_reg    <= DIM_W'(GRID_DIM_MAX);
            rows_reg    <= DIM_W'(GRID_DIM_MAX);
            cnt_reg     <= '0;
            occ_reg     <= '0;
            pend_reg    <= 1'b0;
            rdone_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            cnt_reg     <= cnt_next;
            occ_reg     <= occ_next;
            pend_reg    <= pend_next;
            rdone_reg   <= rdone_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        pidx_reg  <= pidx_next;
        pos_reg   <= pos_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cell_reg  <= cell_next;
        pcell_reg <= pcell_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ENTRY_CAPACITY))
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> ((cnt_reg == $past(cnt_reg) + 1'b1)
            || (cnt_reg == $past(cnt_reg) - 1'b1) || (cnt_reg == '0)))
        else $error("entry count jumped");

    a_empty_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && (cnt_reg == '0)) |-> (occ_reg == '0))
        else $error("occupied cells with no entries");

    a_owner_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_reg.occupant_index != 7'(ENTRY_CAPACITY))
            |-> (CNT_W'(res_reg.occupant_index) < cnt_reg))
        else $error("query owner beyond entry count");

endmodule

// File: sv/grid_rect_first_fit_allocator_unit.sv
`timescale 1ns / 1ps
// one request at a time; a query reads the grid ram, then for an occupied cell the entry ram
// an add runs a key scan over the entry ram, a corner search at one corner per cycle and
// a grid marking sweep over all 64 cells; a remove runs a key scan, an entry shift and a
// 64 cell renumbering pass; a failed remove ends after the key scan
// a finished result waits in the output register while the next request is taken
// reset: 8 x 8 grid, no entries, occupancy bits cleared at once; ram contents left as is
// depends on gfa_pkg, gfa_ram, gfa_ctrl

module grid_rect_first_fit_allocator_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  gfa_pkg::req_t        req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output gfa_pkg::rsp_t        rsp_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [3:0]           cfg_wdata
);
    import gfa_pkg::*;

    ent_port_t           ent_port;
    grid_port_t          grid_port;
    logic [ENT_W-1:0]    ent_rd;
    logic [IDX_W-1:0]    grid_rd;

    gfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .ent_port   (ent_port),
        .ent_rdata  (entry_t'(ent_rd)),
        .grid_port  (grid_port),
        .grid_rdata (grid_rd)
    );

    gfa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRY_CAPACITY)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_port.we),
        .waddr (ent_port.waddr),
        .wdata (ent_port.wdata),
        .raddr (ent_port.raddr),
        .rdata (ent_rd)
    );

    gfa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CELL_COUNT)
    ) u_grid_ram (
        .clk   (clk),
        .we    (grid_port.we),
        .waddr (grid_port.waddr),
        .wdata (grid_port.wdata),
        .raddr (grid_port.raddr),
        .rdata (grid_rd)
    );

endmodule
